/* src/egc_pkg.sv */
// Shared definitions for the elevator group controller.
// Holds parameter defaults, field widths and the command beat passed from front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package egc_pkg;

  localparam int NUM_CARS_DEF   = 2;
  localparam int NUM_FLOORS_DEF = 16;

  localparam int OP_W        = 2;
  localparam int CAR_SEL_W   = 3;
  localparam int FLOOR_IN_W  = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_HALL = 2'd0,
    CMD_CAB  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [CAR_SEL_W-1:0]  car;
    logic [FLOOR_IN_W-1:0] floor;
    logic                  bad_car;
  } cmd_t;

endpackage

`default_nettype wire

/* src/egc_front.sv */
// Front end: accepts input beats, decodes the operation, saturates the floor and checks the car.
// Depends on egc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egc_front #(
  parameter int NUM_CARS   = egc_pkg::NUM_CARS_DEF,
  parameter int NUM_FLOORS = egc_pkg::NUM_FLOORS_DEF
) (
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [egc_pkg::OP_W-1:0]        in_op,
  input  wire logic [egc_pkg::CAR_SEL_W-1:0]   in_car_sel,
  input  wire logic [egc_pkg::FLOOR_IN_W-1:0]  in_target_floor,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output egc_pkg::cmd_t                        q_data
);

  localparam logic [egc_pkg::OP_W-1:0] OP_HALL = 2'd0;
  localparam logic [egc_pkg::OP_W-1:0] OP_CAB  = 2'd1;
  localparam logic [egc_pkg::OP_W-1:0] OP_TICK = 2'd2;
  localparam int SAT_W = 8;

  typedef logic [SAT_W-1:0]                  sat_t;
  typedef logic [egc_pkg::FLOOR_IN_W-1:0]    floor_in_t;
  typedef logic [egc_pkg::CAR_SEL_W:0]       sel_ext_t;

  localparam sat_t     TOP_FLOOR = sat_t'(NUM_FLOORS - 1);
  localparam sel_ext_t CAR_LIMIT = sel_ext_t'(NUM_CARS);

  logic push_ok;

  assign in_stall = q_full;

  always_comb begin
    q_data.car     = in_car_sel;
    q_data.bad_car = 1'b0;
    q_data.floor   = (sat_t'(in_target_floor) > TOP_FLOOR) ? floor_in_t'(TOP_FLOOR)
                                                           : in_target_floor;
    q_data.kind    = egc_pkg::CMD_TICK;
    push_ok        = 1'b1;
    unique case (in_op)
      OP_HALL: begin
        q_data.kind = egc_pkg::CMD_HALL;
      end
      OP_CAB: begin
        q_data.kind    = egc_pkg::CMD_CAB;
        q_data.bad_car = ({1'b0, in_car_sel} >= CAR_LIMIT);
      end
      OP_TICK: begin
        q_data.kind = egc_pkg::CMD_TICK;
      end
      default: begin
        push_ok = 1'b0;
      end
    endcase
  end

  assign q_push = in_valid && !q_full && push_ok;

endmodule

`default_nettype wire

/* src/egc_queue.sv */
// Short command queue between the front end and the car sequencer.
// Depends on egc_pkg for the command beat and the depth.
`timescale 1ns / 1ps
`default_nettype none

module egc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire egc_pkg::cmd_t wr_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output egc_pkg::cmd_t      rd_data
);

  localparam int DEPTH = egc_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  typedef logic [AW-1:0]   ptr_t;
  typedef logic [CNTW-1:0] cnt_t;

  localparam ptr_t LAST_PTR = ptr_t'(DEPTH - 1);
  localparam cnt_t FULL_CNT = cnt_t'(DEPTH);

  egc_pkg::cmd_t mem_r [DEPTH];
  ptr_t wr_ptr_r, rd_ptr_r;
  cnt_t cnt_r;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + ptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + ptr_t'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + cnt_t'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - cnt_t'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/egc_exec.sv */
// Back end: holds the state of every car and carries out calls and ticks one car per cycle
// while the result register is free. Drives the registered result channel. Depends on egc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module egc_exec #(
  parameter int NUM_CARS   = egc_pkg::NUM_CARS_DEF,
  parameter int NUM_FLOORS = egc_pkg::NUM_FLOORS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire egc_pkg::cmd_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_kind,
  output logic [2:0]         out_car_id,
  output logic [3:0]         out_car_floor,
  output logic [1:0]         out_car_direction,
  output logic [1:0]         out_car_mode,
  output logic               out_stopped,
  output logic               out_error,
  output logic               out_last
);

  localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
  localparam int PW = $clog2(NUM_FLOORS);
  localparam int NF = NUM_FLOORS;

  typedef logic [CW-1:0] car_t;
  typedef logic [PW-1:0] pos_t;
  typedef logic [PW:0]   posx_t;
  typedef logic [NF-1:0] map_t;

  typedef enum logic [1:0] {
    DIR_UP   = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_IDLE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MODE_MOVING = 2'd0,
    MODE_IDLE   = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_TICK  = 4'b1000
  } state_t;

  localparam car_t LAST_CAR     = car_t'(NUM_CARS - 1);
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;
  localparam map_t ALL_ONES     = '1;

  state_t        st_r, st_nxt;
  egc_pkg::cmd_t cmd_r, cmd_nxt;
  car_t          idx_r, idx_nxt;
  car_t          best_r, best_nxt;
  pos_t          bestd_r, bestd_nxt;
  logic          found_r, found_nxt;

  pos_t  pos_r  [NUM_CARS];
  dir_t  head_r [NUM_CARS];
  mode_t mode_r [NUM_CARS];
  map_t  pend_r [NUM_CARS];

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_stopped_r, out_error_r, out_last_r;
  logic [2:0] out_car_id_r;
  logic [3:0] out_car_floor_r;
  logic [1:0] out_dir_r, out_mode_r;

  pos_t  cur_pos;
  dir_t  cur_head;
  mode_t cur_mode;
  map_t  cur_pend;
  pos_t  f_pos;
  pos_t  gap;
  logic  has_up, has_dn;
  logic  out_free;
  logic  better;

  pos_t  t_pos;
  dir_t  t_head;
  mode_t t_mode;
  map_t  t_pend;
  logic  t_stop;

  logic  wr_en;
  pos_t  wr_pos;
  dir_t  wr_head;
  mode_t wr_mode;
  map_t  wr_pend;

  logic       emit;
  logic       e_kind, e_stop, e_err, e_last;
  logic [2:0] e_car;

  assign cur_pos  = pos_r[idx_r];
  assign cur_head = head_r[idx_r];
  assign cur_mode = mode_r[idx_r];
  assign cur_pend = pend_r[idx_r];
  assign f_pos    = pos_t'(cmd_r.floor);
  assign gap      = (cur_pos > f_pos) ? cur_pos - f_pos : f_pos - cur_pos;
  assign has_up   = |(cur_pend & (ALL_ONES << (posx_t'(cur_pos) + posx_t'(1))));
  assign has_dn   = |(cur_pend & ~(ALL_ONES << cur_pos));
  assign out_free = !out_valid_r || !out_stall;
  assign better   = (cur_mode == MODE_IDLE) && (!found_r || (gap < bestd_r));

  always_comb begin
    t_pos  = cur_pos;
    t_head = cur_head;
    t_mode = MODE_MOVING;
    t_pend = cur_pend;
    t_stop = 1'b0;
    if (cur_pend == '0) begin
      t_head = DIR_IDLE;
      t_mode = MODE_IDLE;
    end else begin
      if (cur_head == DIR_IDLE && !cur_pend[cur_pos]) begin
        t_head = has_up ? DIR_UP : DIR_DOWN;
      end
      if (t_head == DIR_UP) begin
        if (has_up) begin
          t_pos = cur_pos + pos_t'(1);
        end else if (has_dn) begin
          t_head = DIR_DOWN;
          t_pos  = cur_pos - pos_t'(1);
        end
      end else if (t_head == DIR_DOWN) begin
        if (has_dn) begin
          t_pos = cur_pos - pos_t'(1);
        end else if (has_up) begin
          t_head = DIR_UP;
          t_pos  = cur_pos + pos_t'(1);
        end
      end
      if (cur_pend[t_pos]) begin
        t_pend[t_pos] = 1'b0;
        t_mode        = MODE_OPEN;
        t_stop        = 1'b1;
      end
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    best_nxt  = best_r;
    bestd_nxt = bestd_r;
    found_nxt = found_r;
    q_pop     = 1'b0;
    wr_en     = 1'b0;
    wr_pos    = cur_pos;
    wr_head   = cur_head;
    wr_mode   = cur_mode;
    wr_pend   = cur_pend;
    emit      = 1'b0;
    e_kind    = KIND_ACK;
    e_car     = 3'(idx_r);
    e_stop    = 1'b0;
    e_err     = 1'b0;
    e_last    = 1'b1;
    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          idx_nxt   = '0;
          best_nxt  = '0;
          found_nxt = 1'b0;
          unique case (q_data.kind)
            egc_pkg::CMD_HALL: st_nxt = S_SCAN;
            egc_pkg::CMD_CAB: begin
              st_nxt = S_APPLY;
              if (!q_data.bad_car) begin
                idx_nxt = car_t'(q_data.car);
              end
            end
            egc_pkg::CMD_TICK: st_nxt = S_TICK;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (better) begin
          found_nxt = 1'b1;
          bestd_nxt = gap;
          best_nxt  = idx_r;
        end
        if (idx_r == LAST_CAR) begin
          st_nxt  = S_APPLY;
          idx_nxt = better ? idx_r : best_r;
        end else begin
          idx_nxt = idx_r + car_t'(1);
        end
      end
      S_APPLY: begin
        if (out_free) begin
          emit   = 1'b1;
          st_nxt = S_IDLE;
          if (cmd_r.bad_car) begin
            e_err = 1'b1;
            e_car = cmd_r.car;
          end else begin
            wr_en   = 1'b1;
            wr_pend = cur_pend | (map_t'(1) << f_pos);
            if (f_pos > cur_pos) begin
              wr_head = DIR_UP;
            end else if (f_pos < cur_pos) begin
              wr_head = DIR_DOWN;
            end
          end
        end
      end
      S_TICK: begin
        if (out_free) begin
          emit    = 1'b1;
          wr_en   = 1'b1;
          wr_pos  = t_pos;
          wr_head = t_head;
          wr_mode = t_mode;
          wr_pend = t_pend;
          e_kind  = KIND_STATUS;
          e_stop  = t_stop;
          e_last  = (idx_r == LAST_CAR);
          if (idx_r == LAST_CAR) begin
            st_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + car_t'(1);
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CARS; i++) begin
        pos_r[i]  <= '0;
        head_r[i] <= DIR_IDLE;
        mode_r[i] <= MODE_IDLE;
        pend_r[i] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        pos_r[idx_r]  <= wr_pos;
        head_r[idx_r] <= wr_head;
        mode_r[idx_r] <= wr_mode;
        pend_r[idx_r] <= wr_pend;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    best_r  <= best_nxt;
    bestd_r <= bestd_nxt;
    found_r <= found_nxt;
    if (emit) begin
      out_kind_r      <= e_kind;
      out_car_id_r    <= e_car;
      out_stopped_r   <= e_stop;
      out_error_r     <= e_err;
      out_last_r      <= e_last;
      out_car_floor_r <= e_err ? 4'd0 : 4'(wr_pos);
      out_dir_r       <= e_err ? 2'd0 : wr_head;
      out_mode_r      <= e_err ? 2'd0 : wr_mode;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_car_id        = out_car_id_r;
  assign out_car_floor     = out_car_floor_r;
  assign out_car_direction = out_dir_r;
  assign out_car_mode      = out_mode_r;
  assign out_stopped       = out_stopped_r;
  assign out_error         = out_error_r;
  assign out_last          = out_last_r;

  a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TICK && out_free && idx_r == LAST_CAR) |=> (st_r == S_IDLE))
    else $error("tick sequence did not finish after the last car");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_STATUS && out_last_r)
      |-> (out_car_id_r == 3'(NUM_CARS - 1)))
    else $error("last status beat is not for the highest car");

  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r)
      |-> (out_kind_r == KIND_ACK && out_car_floor_r == 4'd0 && out_last_r && !out_stopped_r))
    else $error("error beat carries car state");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TICK) |-> (cur_pos <= pos_t'(NUM_FLOORS - 1)))
    else $error("car position beyond the top floor");

endmodule

`default_nettype wire

/* src/elevator_group_controller.sv */
// Top level of the elevator group controller.
// Instantiates egc_front, egc_queue and egc_exec; depends on egc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Calls and ticks enter through a two-beat command queue, so the input side keeps accepting
// until it fills while the car sequencer works or the result register is held. The sequencer
// visits one car per cycle, while the result register is free, through a single shared per-car
// unit: a cab call goes from idle to apply, a hall call walks every car in the nearest-idle
// search before apply, and a tick produces one status beat per car in index order. Result beats
// wait in an output register while out_stall is high. Op code 3 is accepted and dropped.

module elevator_group_controller #(
  parameter int NUM_CARS   = egc_pkg::NUM_CARS_DEF,
  parameter int NUM_FLOORS = egc_pkg::NUM_FLOORS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [egc_pkg::OP_W-1:0]        in_op,
  input  wire logic [egc_pkg::CAR_SEL_W-1:0]   in_car_sel,
  input  wire logic [egc_pkg::FLOOR_IN_W-1:0]  in_target_floor,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_kind,
  output logic [2:0]                           out_car_id,
  output logic [3:0]                           out_car_floor,
  output logic [1:0]                           out_car_direction,
  output logic [1:0]                           out_car_mode,
  output logic                                 out_stopped,
  output logic                                 out_error,
  output logic                                 out_last
);

  logic          q_full, q_empty, q_push, q_pop;
  egc_pkg::cmd_t q_wr_data, q_rd_data;

  egc_front #(
    .NUM_CARS   (NUM_CARS),
    .NUM_FLOORS (NUM_FLOORS)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_car_sel      (in_car_sel),
    .in_target_floor (in_target_floor),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wr_data)
  );

  egc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  egc_exec #(
    .NUM_CARS   (NUM_CARS),
    .NUM_FLOORS (NUM_FLOORS)
  ) u_exec (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_rd_data),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_car_id        (out_car_id),
    .out_car_floor     (out_car_floor),
    .out_car_direction (out_car_direction),
    .out_car_mode      (out_car_mode),
    .out_stopped       (out_stopped),
    .out_error         (out_error),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
